// File: rtl/delta_timer_queue_core_assert.svh
// assertion macros used by the delta timer queue core
`ifndef DELTA_TIMER_QUEUE_CORE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define DTQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtq assertion failed");

// next-cycle implication, disabled while reset is held
`define DTQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtq assertion failed");

`endif

// File: rtl/dtq_pkg.sv
// types and codes of the delta timer queue
package dtq_pkg;

    localparam int HND_W = 4;
    localparam int HND_N = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    // what a token asks of the cell it reaches
    typedef enum logic [2:0] {
        TK_NONE,
        TK_SEEK,
        TK_SHIFT,
        TK_FIND,
        TK_PULL
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic [HND_W-1:0] hnd;
    } t_tok;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// File: rtl/delta_timer_queue_core.sv
// delta timer queue: controller and row of sorted delta cells
//
// usage
//   command channel: start with i_action, i_handle, i_key; a transfer happens
//   at a rising edge with start high and busy low. one result per command
//   appears on o_status, o_out_handle, o_out_delta, o_count, o_is_empty for
//   exactly one cycle with o_result_valid high; the receiver cannot stall it
//   and must take it in that cycle.
//   entries are kept in a row of CAPACITY cells, sorted by key, each holding
//   its handle and its delta to the cell before it. a token is launched into
//   the first cell and travels one cell per cycle, inserting, removing or
//   pulling entries as it goes.
// result timing
//   rejected commands, pop of an empty queue and unused actions: result in
//   the cycle after the transfer, busy stays low.
//   insert, erase and pop: one pass of the token along the cell row, result
//   in the cycle after the pass; re-insert of a queued handle runs an erase
//   pass then an insert pass. a pass ends when the pass counter reaches the
//   last cell.
//   a new command may be given in the cycle that shows the result.
// reset
//   synchronous, active low: queue empty, no command pending, no result.
module delta_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_action,
    input  logic [HND_W-1:0] i_handle,
    input  logic [31:0]      i_key,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [HND_W-1:0] o_out_handle,
    output logic [31:0]      o_out_delta,
    output logic [4:0]       o_count,
    output logic             o_is_empty
);

`include "delta_timer_queue_core_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam logic [PW-1:0] LAST_CELL = PW'(CAPACITY - 1);

    // cell row contents, one slot past the end reads as empty
    logic                 ent_occ [CAPACITY+1];
    logic [HND_W-1:0]     ent_hnd [CAPACITY+1];
    logic [KEY_WIDTH-1:0] ent_dlt [CAPACITY+1];
    t_tok                 tok     [CAPACITY+1];
    logic [KEY_WIDTH-1:0] tok_val [CAPACITY+1];

    // control state
    t_state               r_state, n_state;
    t_tok                 r_tok, n_tok;
    logic [KEY_WIDTH-1:0] r_tok_val, n_tok_val;
    logic [PW-1:0]        r_pass, n_pass;
    logic                 r_again, n_again;
    logic [CW-1:0]        r_count, n_count;
    logic [HND_N-1:0]     r_linked, n_linked;
    logic                 r_res_stb, n_res_stb;

    // held operands and result payload
    logic [HND_W-1:0]     r_op_hnd, n_op_hnd;
    logic [KEY_WIDTH-1:0] r_op_key, n_op_key;
    logic [1:0]           r_res_status, n_res_status;
    logic [HND_W-1:0]     r_res_hnd, n_res_hnd;
    logic [31:0]          r_res_dlt, n_res_dlt;

    logic [KEY_WIDTH-1:0] key_w;
    logic                 hnd_ok;
    logic                 q_full;

    assign key_w  = KEY_WIDTH'(i_key);
    assign hnd_ok = (32'(i_handle) < CAPACITY);
    assign q_full = (32'(r_count) >= CAPACITY);

    assign ent_occ[CAPACITY] = 1'b0;
    assign ent_hnd[CAPACITY] = '0;
    assign ent_dlt[CAPACITY] = '0;
    assign tok[0]            = r_tok;
    assign tok_val[0]        = r_tok_val;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dtq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok[g]),
            .i_tok_val (tok_val[g]),
            .i_nbr_occ (ent_occ[g+1]),
            .i_nbr_hnd (ent_hnd[g+1]),
            .i_nbr_dlt (ent_dlt[g+1]),
            .o_occ     (ent_occ[g]),
            .o_hnd     (ent_hnd[g]),
            .o_dlt     (ent_dlt[g]),
            .o_tok     (tok[g+1]),
            .o_tok_val (tok_val[g+1])
        );
    end

    // command decode, pass sequencing and result timing
    always_comb begin
        n_state      = r_state;
        n_tok        = '{mode: TK_NONE, hnd: '0};
        n_tok_val    = '0;
        n_pass       = r_pass;
        n_again      = r_again;
        n_count      = r_count;
        n_linked     = r_linked;
        n_res_stb    = 1'b0;
        n_op_hnd     = r_op_hnd;
        n_op_key     = r_op_key;
        n_res_status = r_res_status;
        n_res_hnd    = r_res_hnd;
        n_res_dlt    = r_res_dlt;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_res_status = STS_OK;
                    n_res_hnd    = '0;
                    n_res_dlt    = '0;
                    n_op_hnd     = i_handle;
                    n_op_key     = key_w;
                    n_pass       = '0;
                    unique case (i_action)
                        ACT_INSERT: begin
                            if (!hnd_ok) begin
                                n_res_status = STS_FULL;
                                n_res_stb    = 1'b1;
                            end else if (r_linked[i_handle]) begin
                                // take it out first, then insert at the new key
                                n_tok   = '{mode: TK_FIND, hnd: i_handle};
                                n_again = 1'b1;
                                n_state = ST_RUN;
                            end else if (q_full) begin
                                n_res_status = STS_FULL;
                                n_res_stb    = 1'b1;
                            end else begin
                                n_tok              = '{mode: TK_SEEK, hnd: i_handle};
                                n_tok_val          = key_w;
                                n_again            = 1'b0;
                                n_count            = r_count + 1'b1;
                                n_linked[i_handle] = 1'b1;
                                n_state            = ST_RUN;
                            end
                        end
                        ACT_ERASE: begin
                            if (hnd_ok && r_linked[i_handle]) begin
                                n_tok              = '{mode: TK_FIND, hnd: i_handle};
                                n_again            = 1'b0;
                                n_count            = r_count - 1'b1;
                                n_linked[i_handle] = 1'b0;
                                n_state            = ST_RUN;
                            end else begin
                                n_res_status = STS_MISS;
                                n_res_stb    = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (r_count != '0) begin
                                // head leaves as is, the rest shifts toward it
                                n_res_hnd           = ent_hnd[0];
                                n_res_dlt           = 32'(ent_dlt[0]);
                                n_tok               = '{mode: TK_PULL, hnd: '0};
                                n_again             = 1'b0;
                                n_count             = r_count - 1'b1;
                                n_linked[ent_hnd[0]] = 1'b0;
                                n_state             = ST_RUN;
                            end else begin
                                n_res_status = STS_MISS;
                                n_res_stb    = 1'b1;
                            end
                        end
                        default: begin
                            n_res_stb = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_pass = r_pass + 1'b1;
                if (r_pass == LAST_CELL) begin
                    n_pass = '0;
                    if (r_again) begin
                        n_again   = 1'b0;
                        n_tok     = '{mode: TK_SEEK, hnd: r_op_hnd};
                        n_tok_val = r_op_key;
                    end else begin
                        n_state   = ST_IDLE;
                        n_res_stb = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tok      <= '{mode: TK_NONE, hnd: '0};
            r_pass     <= '0;
            r_again    <= 1'b0;
            r_count    <= '0;
            r_linked   <= '0;
            r_res_stb  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tok      <= n_tok;
            r_pass     <= n_pass;
            r_again    <= n_again;
            r_count    <= n_count;
            r_linked   <= n_linked;
            r_res_stb  <= n_res_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_val    <= n_tok_val;
        r_op_hnd     <= n_op_hnd;
        r_op_key     <= n_op_key;
        r_res_status <= n_res_status;
        r_res_hnd    <= n_res_hnd;
        r_res_dlt    <= n_res_dlt;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_res_stb;
    assign o_status       = r_res_status;
    assign o_out_handle   = r_res_hnd;
    assign o_out_delta    = r_res_dlt;
    assign o_count        = 5'(r_count);
    assign o_is_empty     = (r_count == '0);

    // no result transfer while a pass is still walking the row
    `DTQ_ASSERT_IMP(a_no_result_in_pass, i_clk, i_rst_n, r_state == ST_RUN, !r_res_stb)
    // the count always matches the set of queued handles
    `DTQ_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, $countones(r_linked) == 32'(r_count))
    // a token never runs off the end of the row
    `DTQ_ASSERT_IMP(a_row_end_quiet, i_clk, i_rst_n, 1'b1,
        (tok[CAPACITY].mode == TK_NONE) && (tok_val[CAPACITY] == '0))
    // tokens are only launched while a pass runs
    `DTQ_ASSERT_IMP(a_tok_in_pass, i_clk, i_rst_n, r_tok.mode != TK_NONE, r_state == ST_RUN)
    // pop of an empty queue answers with a miss without starting a pass
    `DTQ_ASSERT_NXT(a_pop_empty, i_clk, i_rst_n,
        start && !busy && (i_action == ACT_POP) && (r_count == '0),
        r_res_stb && (r_res_status == STS_MISS) && !busy)

endmodule

// File: rtl/dtq_cell.sv
// one slot of the sorted delta row, acting on the token that passes through it
module dtq_cell
    import dtq_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tok                 i_tok,
    input  logic [KEY_WIDTH-1:0] i_tok_val,
    input  logic                 i_nbr_occ,
    input  logic [HND_W-1:0]     i_nbr_hnd,
    input  logic [KEY_WIDTH-1:0] i_nbr_dlt,
    output logic                 o_occ,
    output logic [HND_W-1:0]     o_hnd,
    output logic [KEY_WIDTH-1:0] o_dlt,
    output t_tok                 o_tok,
    output logic [KEY_WIDTH-1:0] o_tok_val
);

    logic                 r_occ, n_occ;
    logic [HND_W-1:0]     r_hnd, n_hnd;
    logic [KEY_WIDTH-1:0] r_dlt, n_dlt;
    t_tok                 r_tok, n_tok;
    logic [KEY_WIDTH-1:0] r_tok_val, n_tok_val;

    always_comb begin
        n_occ     = r_occ;
        n_hnd     = r_hnd;
        n_dlt     = r_dlt;
        n_tok     = '{mode: TK_NONE, hnd: '0};
        n_tok_val = '0;
        unique case (i_tok.mode)
            TK_SEEK: begin
                if (!r_occ || (r_dlt > i_tok_val)) begin
                    // new entry lands here, old one moves right with reduced delta
                    n_occ = 1'b1;
                    n_hnd = i_tok.hnd;
                    n_dlt = i_tok_val;
                    if (r_occ) begin
                        n_tok     = '{mode: TK_SHIFT, hnd: r_hnd};
                        n_tok_val = r_dlt - i_tok_val;
                    end
                end else begin
                    n_tok     = i_tok;
                    n_tok_val = i_tok_val - r_dlt;
                end
            end
            TK_SHIFT: begin
                n_occ = 1'b1;
                n_hnd = i_tok.hnd;
                n_dlt = i_tok_val;
                if (r_occ) begin
                    n_tok     = '{mode: TK_SHIFT, hnd: r_hnd};
                    n_tok_val = r_dlt;
                end
            end
            TK_FIND: begin
                if (r_occ && (r_hnd == i_tok.hnd)) begin
                    // removed entry's delta goes to its successor
                    n_occ = i_nbr_occ;
                    n_hnd = i_nbr_hnd;
                    n_dlt = i_nbr_dlt + r_dlt;
                    if (i_nbr_occ) begin
                        n_tok = '{mode: TK_PULL, hnd: '0};
                    end
                end else begin
                    n_tok = i_tok;
                end
            end
            TK_PULL: begin
                n_occ = i_nbr_occ;
                n_hnd = i_nbr_hnd;
                n_dlt = i_nbr_dlt;
                if (i_nbr_occ) begin
                    n_tok = '{mode: TK_PULL, hnd: '0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= '{mode: TK_NONE, hnd: '0};
        end else begin
            r_occ <= n_occ;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hnd     <= n_hnd;
        r_dlt     <= n_dlt;
        r_tok_val <= n_tok_val;
    end

    assign o_occ     = r_occ;
    assign o_hnd     = r_hnd;
    assign o_dlt     = r_dlt;
    assign o_tok     = r_tok;
    assign o_tok_val = r_tok_val;

endmodule

// File: tb/delta_timer_queue_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the delta timer queue core with its own delta-list predictor
module delta_timer_queue_core_test;
    import dtq_pkg::*;

    // run length and limits
    localparam int LIMIT_CYCLES = 800000;
    localparam int RANDOM_ITEMS = 2000;
    // longest command is a re-insert, erase pass plus insert pass
    localparam int DRAIN_CYCLES = 2 * HND_N + 8;

    // action code that the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // end-of-list marker of the predictor links
    localparam logic [4:0] LINK_NIL = 5'(HND_N);

    // fields of one result
    typedef struct packed {
        logic [1:0]       status;
        logic [HND_W-1:0] hnd;
        logic [31:0]      delta;
        logic [4:0]       cnt;
        logic             is_empty;
    } t_reply;

    localparam t_reply NO_REPLY = '0;

    // one row of the directed table, repeated reps times with handle and key stepping
    typedef struct {
        logic [1:0]       action;
        logic [HND_W-1:0] hnd;
        logic [31:0]      key;
        int               reps;
        int               key_step;
        bit               literal;
        t_reply           want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_action;
    logic [HND_W-1:0] i_handle;
    logic [31:0]      i_key;
    logic             o_result_valid;
    logic [1:0]       o_status;
    logic [HND_W-1:0] o_out_handle;
    logic [31:0]      o_out_delta;
    logic [4:0]       o_count;
    logic             o_is_empty;

    // literal expectation travelling with the command now on the inputs
    bit     lit_now;
    t_reply lit_reply;

    // predictor copy of the delta list
    logic [31:0] dl_delta [HND_N];
    logic [4:0]  dl_next [HND_N];
    logic [4:0]  dl_head;
    logic [4:0]  dl_count;

    // results still owed by the block, oldest first
    t_reply pending_replies [$];
    t_row   stim_table [$];

    int errors;
    int cycles;

    delta_timer_queue_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_handle       (i_handle),
        .i_key          (i_key),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_out_handle   (o_out_handle),
        .o_out_delta    (o_out_delta),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // search the list for handle h, give back its predecessor
    function automatic bit dl_find(input logic [4:0] h, output logic [4:0] pred);
        logic [4:0] prev;
        logic [4:0] cur;
        int steps;
        prev = LINK_NIL;
        cur  = dl_head;
        pred = LINK_NIL;
        for (steps = 0; steps < HND_N && cur < LINK_NIL; steps++) begin
            if (cur == h) begin
                pred = prev;
                return 1'b1;
            end
            prev = cur;
            cur  = dl_next[cur[3:0]];
        end
        return 1'b0;
    endfunction

    // take h out, its delta moves to the successor
    function automatic void dl_unlink(input logic [4:0] h, input logic [4:0] pred);
        logic [4:0] nx;
        nx = dl_next[h[3:0]];
        if (nx < LINK_NIL)
            dl_delta[nx[3:0]] = dl_delta[nx[3:0]] + dl_delta[h[3:0]];
        if (pred < LINK_NIL)
            dl_next[pred[3:0]] = nx;
        else
            dl_head = nx;
        dl_next[h[3:0]] = LINK_NIL;
        if (dl_count > 0)
            dl_count = dl_count - 5'd1;
    endfunction

    // place h by key, after any equal keys, and trim the successor
    function automatic void dl_link(input logic [4:0] h, input logic [31:0] key);
        logic [4:0]  prev;
        logic [4:0]  cur;
        logic [31:0] accum;
        logic [31:0] d;
        int steps;
        prev  = LINK_NIL;
        cur   = dl_head;
        accum = '0;
        for (steps = 0; steps < HND_N && cur < LINK_NIL; steps++) begin
            if ({32'h0, dl_delta[cur[3:0]]} > ({32'h0, key} - {32'h0, accum}))
                break;
            accum = accum + dl_delta[cur[3:0]];
            prev  = cur;
            cur   = dl_next[cur[3:0]];
        end
        if (cur >= LINK_NIL)
            cur = LINK_NIL;
        d = key - accum;
        dl_delta[h[3:0]] = d;
        dl_next[h[3:0]]  = cur;
        if (prev < LINK_NIL)
            dl_next[prev[3:0]] = h;
        else
            dl_head = h;
        if (cur < LINK_NIL)
            dl_delta[cur[3:0]] = dl_delta[cur[3:0]] - d;
        dl_count = dl_count + 5'd1;
    endfunction

    // apply one command to the predictor list and give the result it owes
    function automatic t_reply queue_apply(input logic [1:0] action, input logic [HND_W-1:0] h,
                                           input logic [31:0] key);
        t_reply r;
        logic [4:0] pred;
        logic [4:0] top;
        r = NO_REPLY;
        r.status = STS_OK;
        case (action)
            ACT_INSERT: begin
                if (dl_find({1'b0, h}, pred)) begin
                    // re-insert of a queued handle
                    dl_unlink({1'b0, h}, pred);
                    dl_link({1'b0, h}, key);
                end else if (dl_count >= 5'(HND_N)) begin
                    r.status = STS_FULL;
                end else begin
                    dl_link({1'b0, h}, key);
                end
            end
            ACT_ERASE: begin
                if (dl_find({1'b0, h}, pred))
                    dl_unlink({1'b0, h}, pred);
                else
                    r.status = STS_MISS;
            end
            ACT_POP: begin
                if (dl_head < LINK_NIL) begin
                    // successor keeps its delta, the base moves on
                    top = dl_head;
                    r.hnd   = top[3:0];
                    r.delta = dl_delta[top[3:0]];
                    dl_head = dl_next[top[3:0]];
                    dl_next[top[3:0]] = LINK_NIL;
                    if (dl_count > 0)
                        dl_count = dl_count - 5'd1;
                end else begin
                    r.status = STS_MISS;
                end
            end
            default: begin
            end
        endcase
        r.cnt      = dl_count;
        r.is_empty = (dl_count == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result check first, then the prediction for a transfer at this edge
    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            if (o_result_valid) begin
                got = '{o_status, o_out_handle, o_out_delta, o_count, o_is_empty};
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    errors++;
                end else begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("out_handle", 32'(want.hnd), 32'(got.hnd));
                    check_field("out_delta", want.delta, got.delta);
                    check_field("count", 32'(want.cnt), 32'(got.cnt));
                    check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                end
            end
            if (start && !busy) begin
                want = queue_apply(i_action, i_handle, i_key);
                pending_replies.push_back(lit_now ? lit_reply : want);
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_row mk_row(input logic [1:0] a, input logic [HND_W-1:0] h,
                                    input logic [31:0] k, input int reps, input int step,
                                    input bit lit, input t_reply want);
        t_row row;
        row.action   = a;
        row.hnd      = h;
        row.key      = k;
        row.reps     = reps;
        row.key_step = step;
        row.literal  = lit;
        row.want     = want;
        return row;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] a, input logic [HND_W-1:0] h,
                            input logic [31:0] k, input bit lit, input t_reply want);
        i_action  = a;
        i_handle  = h;
        i_key     = k;
        lit_now   = lit;
        lit_reply = want;
        start     = 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            start   = 1'b0;
            lit_now = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(0, 40));     // many equal keys
            4:       return $urandom;
            default: return $urandom & 32'h0000_FFFF;
        endcase
    endfunction

    initial begin
        int items_sent;
        int burst_len;
        int mode;
        int roll;
        int i;
        logic [1:0] act;

        errors  = 0;
        cycles  = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_action  = ACT_INSERT;
        i_handle  = '0;
        i_key     = '0;
        lit_now   = 1'b0;
        lit_reply = NO_REPLY;

        // predictor reset: empty list
        for (i = 0; i < HND_N; i++) begin
            dl_delta[i] = '0;
            dl_next[i]  = LINK_NIL;
        end
        dl_head  = LINK_NIL;
        dl_count = '0;

        // directed table
        stim_table.push_back(mk_row(ACT_POP, 4'd0, 32'h0, 1, 0, 1'b1,
                                    '{STS_MISS, 4'd0, 32'h0, 5'd0, 1'b1}));  // pop of empty
        stim_table.push_back(mk_row(ACT_ERASE, 4'd9, 32'h0, 1, 0, 1'b1,
                                    '{STS_MISS, 4'd0, 32'h0, 5'd0, 1'b1}));  // erase on empty
        stim_table.push_back(mk_row(ACT_UNUSED, 4'd3, 32'h1234, 1, 0, 1'b1,
                                    '{STS_OK, 4'd0, 32'h0, 5'd0, 1'b1}));    // ignored action
        stim_table.push_back(mk_row(ACT_INSERT, 4'd0, 32'h0, 1, 0, 1'b1,
                                    '{STS_OK, 4'd0, 32'h0, 5'd1, 1'b0}));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd15, 32'hFFFF_FFFF, 1, 0, 1'b1,
                                    '{STS_OK, 4'd0, 32'h0, 5'd2, 1'b0}));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd7, 32'd100, 1, 0, 1'b0, NO_REPLY));
        // equal key lands after the existing one
        stim_table.push_back(mk_row(ACT_INSERT, 4'd8, 32'd100, 1, 0, 1'b0, NO_REPLY));
        // re-insert of a queued handle
        stim_table.push_back(mk_row(ACT_INSERT, 4'd7, 32'd50, 1, 0, 1'b0, NO_REPLY));
        stim_table.push_back(mk_row(ACT_ERASE, 4'd8, 32'h0, 1, 0, 1'b0, NO_REPLY));
        // erase of a handle not queued
        stim_table.push_back(mk_row(ACT_ERASE, 4'd8, 32'h0, 1, 0, 1'b1,
                                    '{STS_MISS, 4'd0, 32'h0, 5'd3, 1'b0}));
        stim_table.push_back(mk_row(ACT_POP, 4'd0, 32'h0, 1, 0, 1'b1,
                                    '{STS_OK, 4'd0, 32'h0, 5'd2, 1'b0}));
        stim_table.push_back(mk_row(ACT_UNUSED, 4'd12, 32'hFFFF_FFFF, 1, 0, 1'b0, NO_REPLY));
        // fill the queue up to capacity
        stim_table.push_back(mk_row(ACT_INSERT, 4'd1, 32'd10, 6, 10, 1'b0, NO_REPLY));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd8, 32'd50, 7, 0, 1'b0, NO_REPLY));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd0, 32'h8000_0000, 1, 0, 1'b0, NO_REPLY));
        // re-insert while full
        stim_table.push_back(mk_row(ACT_INSERT, 4'd3, 32'd7, 1, 0, 1'b0, NO_REPLY));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd15, 32'h0, 1, 0, 1'b0, NO_REPLY));
        // drain it all
        stim_table.push_back(mk_row(ACT_POP, 4'd0, 32'h0, 16, 0, 1'b0, NO_REPLY));
        stim_table.push_back(mk_row(ACT_POP, 4'd0, 32'h0, 1, 0, 1'b1,
                                    '{STS_MISS, 4'd0, 32'h0, 5'd0, 1'b1}));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd5, 32'hFFFF_FFFF, 1, 0, 1'b1,
                                    '{STS_OK, 4'd0, 32'h0, 5'd1, 1'b0}));
        stim_table.push_back(mk_row(ACT_INSERT, 4'd6, 32'h0, 1, 0, 1'b0, NO_REPLY));
        // erase of the head hands its delta on
        stim_table.push_back(mk_row(ACT_ERASE, 4'd6, 32'h0, 1, 0, 1'b0, NO_REPLY));
        stim_table.push_back(mk_row(ACT_POP, 4'd0, 32'h0, 1, 0, 1'b1,
                                    '{STS_OK, 4'd5, 32'hFFFF_FFFF, 5'd0, 1'b1}));

        // reset held, then released at a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (stim_table[r]) begin
            for (i = 0; i < stim_table[r].reps; i++)
                send_cmd(stim_table[r].action, stim_table[r].hnd + HND_W'(i),
                         stim_table[r].key + 32'(i * stim_table[r].key_step),
                         stim_table[r].literal, stim_table[r].want);
            if ($urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 4));
        end

        // random part: bursts leaning toward filling, draining or a mix
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 24);
            mode = $urandom_range(0, 2);
            for (i = 0; i < burst_len; i++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       act = (roll < 75) ? ACT_INSERT : (roll < 85) ? ACT_ERASE :
                                   (roll < 97) ? ACT_POP : ACT_UNUSED;
                    1:       act = (roll < 20) ? ACT_INSERT : (roll < 55) ? ACT_ERASE :
                                   (roll < 97) ? ACT_POP : ACT_UNUSED;
                    default: act = (roll < 45) ? ACT_INSERT : (roll < 70) ? ACT_ERASE :
                                   (roll < 97) ? ACT_POP : ACT_UNUSED;
                endcase
                send_cmd(act, HND_W'($urandom_range(0, HND_N - 1)), pick_key(), 1'b0, NO_REPLY);
                // ignored commands do not count
                if (act != ACT_UNUSED)
                    items_sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 30));
        end

        // wait for the last results, then a quiet stretch for strays
        idle_for(1);
        while (pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
